[rtl/srsc_pkg.sv]
// Package with payload types and constants of the shadow return stack checker.
package srsc_pkg;

   localparam logic [63:0] HASH_MULT = 64'd2654435761;
   localparam int MAX_SEARCH = 4;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd3;

   localparam logic OP_CALL = 1'b0;
   localparam logic OP_RETURN = 1'b1;

   localparam logic [0:0] REG_SEARCH_DEPTH = 1'd0;

   typedef struct packed {
      logic        opcode;
      logic [4:0]  thread_id;
      logic [63:0] ret_address;
      logic [63:0] call_target;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        mismatch;
      logic [2:0]  match_depth;
      logic [63:0] mismatch_target;
      logic [31:0] mismatch_count;
   } rsp_type;

endpackage

[rtl/srsc_ram.sv]
// Generic single-port RAM with registered read.
module srsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write or read one entry per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/shadow_return_stack_checker.sv]
// Shadow return stack checker: per-thread call stacks and a mismatch table.
// A mismatching return probes the table ways and then reads deeper stack entries serially,
// up to a limit of search_depth clamped to 1..4 and to the fill level.
// Throughput: one word at a time; the next is taken in the cycle after its result is loaded.
// Reset: synchronous; fills and search_depth (4) are set, then a clearing pass over all
// TABLE_BUCKETS*TABLE_WAYS entries clears the table before the first word is taken.
module shadow_return_stack_checker #(
   parameter int THREADS = 32,
   parameter int STACK_DEPTH = 64,
   parameter int TABLE_BUCKETS = 256,
   parameter int TABLE_WAYS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srsc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srsc_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int FW = $clog2(STACK_DEPTH + 1);
   localparam int BW = $clog2(TABLE_BUCKETS);
   localparam int WW = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
   localparam int TE = TABLE_BUCKETS * TABLE_WAYS;
   localparam int EW = $clog2(TE);
   localparam int SAW = (THREADS > 1) ? TW + SW : SW;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_TOP = 4'd2;
   localparam logic [3:0] S_TOPCHK = 4'd3;
   localparam logic [3:0] S_HASH = 4'd4;
   localparam logic [3:0] S_PROBE = 4'd5;
   localparam logic [3:0] S_PCHK = 4'd6;
   localparam logic [3:0] S_WRITE = 4'd7;
   localparam logic [3:0] S_SRCH = 4'd8;
   localparam logic [3:0] S_SCHK = 4'd9;
   localparam logic [3:0] S_OUT = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [2:0]         sdepth_ff;
   logic [FW-1:0]      fill_ff [THREADS];
   logic [EW-1:0]      clr_ff;
   srsc_pkg::req_type  req_ff;
   srsc_pkg::rsp_type  rsp_ff;
   srsc_pkg::rsp_type  rsp_out_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]      tid_ff;
   logic [FW-1:0]      fill_cur_ff;
   logic [2:0]         lim_ff, d_ff;
   logic [BW-1:0]      set_ff;
   logic [WW-1:0]      way_ff;
   logic               hit_ff, free_ff;
   logic [WW-1:0]      free_way_ff;
   logic [63:0]        hash_prod_ff;

   // Stack and table memories; the key memory holds a valid bit above the key.
   logic               st_we, tb_we;
   logic [SAW-1:0]     st_addr;
   logic [EW-1:0]      tb_addr;
   logic [63:0]        ra_rd, ct_rd;
   logic [64:0]        key_rd, key_wr;
   logic [31:0]        cnt_rd, cnt_wr;

   srsc_ram #(.WIDTH(64), .DEPTH(THREADS * STACK_DEPTH)) u_ra (
      .clock(clock), .wr_en(st_we), .addr(st_addr),
      .wr_data(req_ff.ret_address), .rd_data(ra_rd));
   srsc_ram #(.WIDTH(64), .DEPTH(THREADS * STACK_DEPTH)) u_ct (
      .clock(clock), .wr_en(st_we), .addr(st_addr),
      .wr_data(req_ff.call_target), .rd_data(ct_rd));
   srsc_ram #(.WIDTH(65), .DEPTH(TE)) u_key (
      .clock(clock), .wr_en(tb_we), .addr(tb_addr),
      .wr_data(key_wr), .rd_data(key_rd));
   srsc_ram #(.WIDTH(32), .DEPTH(TE)) u_cnt (
      .clock(clock), .wr_en(tb_we), .addr(tb_addr),
      .wr_data(cnt_wr), .rd_data(cnt_rd));

   logic [FW-1:0] pos;
   logic [EW-1:0] wr_ent;
   logic          slot_valid;
   logic          out_free;
   logic [31:0]   mul_a;
   logic [63:0]   mul_p, hash_sum;

   assign wr_ent = EW'(set_ff * TABLE_WAYS + (hit_ff ? way_ff : free_way_ff));
   assign slot_valid = key_rd[64];
   assign key_wr = (state_ff == S_CLEAR) ? 65'd0 : {1'b1, rsp_ff.mismatch_target};

   // Hash multiply in two halves on one 32 by 32 multiplier.
   assign mul_a = (state_ff == S_TOPCHK) ? ct_rd[31:0] : rsp_ff.mismatch_target[63:32];
   assign mul_p = {32'd0, mul_a} * {32'd0, srsc_pkg::HASH_MULT[31:0]};
   assign hash_sum = hash_prod_ff + {mul_p[31:0], 32'd0};

   // Stack address: push slot in the top state for a call, else fill - d.
   always_comb begin
      pos = fill_cur_ff - FW'(d_ff);
      if (state_ff == S_TOP && req_ff.opcode == srsc_pkg::OP_CALL) begin
         pos = fill_cur_ff;
      end
      st_addr = SAW'(tid_ff * STACK_DEPTH + SW'(pos));
      st_we = (state_ff == S_TOP) && (req_ff.opcode == srsc_pkg::OP_CALL) &&
              (fill_cur_ff < FW'(STACK_DEPTH));
      if (state_ff == S_CLEAR) begin
         tb_addr = clr_ff;
      end else if (state_ff == S_WRITE) begin
         tb_addr = wr_ent;
      end else begin
         tb_addr = EW'(set_ff * TABLE_WAYS + way_ff);
      end
      tb_we = (state_ff == S_CLEAR) || ((state_ff == S_WRITE) && (hit_ff || free_ff));
      cnt_wr = hit_ff ? ((cnt_rd == 32'hFFFF_FFFF) ? cnt_rd : cnt_rd + 32'd1) : 32'd1;
   end

   // Output register: a result word is loaded when the previous one is gone or leaving.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_out_ff;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == srsc_pkg::REG_SEARCH_DEPTH) ? {29'd0, sdepth_ff} : 32'd0;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (clr_ff == EW'(TE - 1)) state_in = S_IDLE;
         S_IDLE:   if (req_valid && req_ready) state_in = S_TOP;
         S_TOP: begin
            if (req_ff.opcode == srsc_pkg::OP_CALL || fill_cur_ff == '0) begin
               state_in = S_OUT;
            end else begin
               state_in = S_TOPCHK;
            end
         end
         S_TOPCHK: state_in = (ra_rd == req_ff.ret_address) ? S_OUT : S_HASH;
         S_HASH:   state_in = S_PROBE;
         S_PROBE:  state_in = S_PCHK;
         S_PCHK: begin
            if ((slot_valid && key_rd[63:0] == rsp_ff.mismatch_target) ||
                way_ff == WW'(TABLE_WAYS - 1)) begin
               state_in = S_WRITE;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_WRITE:  state_in = (lim_ff >= 3'd2) ? S_SRCH : S_OUT;
         S_SRCH:   state_in = S_SCHK;
         S_SCHK: begin
            if (ra_rd == req_ff.ret_address || d_ff == lim_ff) begin
               state_in = S_OUT;
            end else begin
               state_in = S_SRCH;
            end
         end
         S_OUT:    state_in = out_free ? S_IDLE : S_OUT;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath registers and control updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sdepth_ff <= 3'd4;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < THREADS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (psel && penable && pwrite && paddr[2] == srsc_pkg::REG_SEARCH_DEPTH) begin
            sdepth_ff <= pwdata[2:0];
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + EW'(1);
            end
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff <= req_data;
                  tid_ff <= TW'(req_data.thread_id % THREADS);
                  fill_cur_ff <= fill_ff[TW'(req_data.thread_id % THREADS)];
                  d_ff <= 3'd1;
                  rsp_ff <= '0;
               end
            end
            S_TOP: begin
               if (req_ff.opcode == srsc_pkg::OP_CALL) begin
                  if (fill_cur_ff < FW'(STACK_DEPTH)) begin
                     fill_ff[tid_ff] <= fill_cur_ff + FW'(1);
                  end else begin
                     rsp_ff.status <= srsc_pkg::STATUS_FULL;
                  end
               end else if (fill_cur_ff == '0) begin
                  rsp_ff.status <= srsc_pkg::STATUS_EMPTY;
               end
               // Search limit clamped to 1..4 and to the fill level.
               if (sdepth_ff == 3'd0) begin
                  lim_ff <= 3'd1;
               end else if (sdepth_ff > 3'(srsc_pkg::MAX_SEARCH)) begin
                  lim_ff <= (fill_cur_ff < FW'(srsc_pkg::MAX_SEARCH)) ?
                            3'(fill_cur_ff) : 3'(srsc_pkg::MAX_SEARCH);
               end else begin
                  lim_ff <= (fill_cur_ff < FW'(sdepth_ff)) ? 3'(fill_cur_ff) : sdepth_ff;
               end
            end
            S_TOPCHK: begin
               if (ra_rd == req_ff.ret_address) begin
                  fill_ff[tid_ff] <= fill_cur_ff - FW'(1);
                  rsp_ff.match_depth <= 3'd1;
               end else begin
                  rsp_ff.mismatch <= 1'b1;
                  rsp_ff.mismatch_target <= ct_rd;
                  hash_prod_ff <= mul_p;
               end
            end
            S_HASH: begin
               set_ff <= BW'(hash_sum % TABLE_BUCKETS);
               way_ff <= '0;
               hit_ff <= 1'b0;
               free_ff <= 1'b0;
               free_way_ff <= '0;
            end
            S_PCHK: begin
               if (slot_valid && key_rd[63:0] == rsp_ff.mismatch_target) begin
                  hit_ff <= 1'b1;
               end else begin
                  if (!slot_valid && !free_ff) begin
                     free_ff <= 1'b1;
                     free_way_ff <= way_ff;
                  end
                  if (way_ff != WW'(TABLE_WAYS - 1)) begin
                     way_ff <= way_ff + WW'(1);
                  end
               end
            end
            S_WRITE: begin
               if (hit_ff || free_ff) begin
                  rsp_ff.mismatch_count <= cnt_wr;
               end else begin
                  rsp_ff.status <= srsc_pkg::STATUS_TABLE_FULL;
               end
               d_ff <= 3'd2;
            end
            S_SCHK: begin
               if (ra_rd == req_ff.ret_address) begin
                  fill_ff[tid_ff] <= fill_cur_ff - FW'(d_ff);
                  rsp_ff.match_depth <= d_ff;
               end else begin
                  d_ff <= d_ff + 3'd1;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_out_ff <= rsp_ff;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
